/* hdl/htm_pkg.sv */
// shared constants and types for the hdr tone mapper
package htm_pkg;

  localparam int GAIN_W  = 16;
  localparam int CURVE_W = 27;
  localparam int SHIFT_W = 5;
  localparam int FRAC_W  = 64;
  localparam int SQ_W    = 2 * CURVE_W;
  localparam int XU_W    = CURVE_W + 16;
  localparam int U2_W    = 33;

  typedef logic [2:0] op_code_t;
  typedef logic       reg_idx_t;

  localparam op_code_t OP_LINEAR   = 3'd0;
  localparam op_code_t OP_REINHARD = 3'd1;
  localparam op_code_t OP_JODIE    = 3'd2;
  localparam op_code_t OP_ACES     = 3'd3;
  localparam op_code_t OP_UNCH     = 3'd4;
  localparam op_code_t OP_FILMIC   = 3'd5;

  localparam reg_idx_t REG_OPERATOR = 1'b0;
  localparam reg_idx_t REG_EXPOSURE = 1'b1;

  localparam logic [SHIFT_W-1:0] UNIT_SHIFT    = 5'd16;
  localparam logic [FRAC_W-1:0]  UNIT_ONE      = 64'd65536;
  localparam logic [8:0]         FILMIC_OFFSET = 9'd262;

  // curve coefficients: num = A x^2 + B xu, den = C x^2 + D xu + E u^2
  localparam logic [9:0] ACES_A = 10'd251, ACES_B = 10'd3, ACES_C = 10'd243;
  localparam logic [9:0] ACES_D = 10'd59, ACES_E = 10'd14;
  localparam logic [9:0] UNCH_A = 10'd210, UNCH_B = 10'd25, UNCH_C = 10'd225;
  localparam logic [9:0] UNCH_D = 10'd750, UNCH_E = 10'd90;
  localparam logic [9:0] FILM_A = 10'd310, FILM_B = 10'd25, FILM_C = 10'd310;
  localparam logic [9:0] FILM_D = 10'd85, FILM_E = 10'd3;

  // bt.709 luminance weights times 10000
  localparam logic [13:0] LUM_R = 14'd2126;
  localparam logic [13:0] LUM_G = 14'd7152;
  localparam logic [13:0] LUM_B = 14'd722;
  localparam logic [29:0] JODIE_BASE = 30'd655360000;

endpackage

/* hdl/htm_front.sv */
// per-channel front end: exposure, range scaling and curve terms
module htm_front import htm_pkg::*; #(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [W-1:0]          chan,
  input  logic [GAIN_W-1:0]     gain,
  input  op_code_t              op,
  output logic [W+GAIN_W-1:0]   x_s1,
  output logic                  out_valid,
  output logic [FRAC_W-1:0]     num,
  output logic [FRAC_W-1:0]     den
);

  localparam int XW = W + GAIN_W;

  logic [4:0]           v_r;
  logic [XW-1:0]        x1_r, x2_r, x3_r, x4_r;
  logic [CURVE_W-1:0]   xs2_r;
  logic [SHIFT_W-1:0]   ush2_r;
  logic [SQ_W-1:0]      sq3_r;
  logic [XU_W-1:0]      xu3_r;
  logic [U2_W-1:0]      u2_3_r;
  logic [FRAC_W-1:0]    ta_r, tb_r, tc_r, td_r, te_r, num_r, den_r;

  logic [XW-1:0]        xf;
  logic [SHIFT_W-1:0]   sh;
  logic [CURVE_W-1:0]   xs;
  logic [SHIFT_W-1:0]   ush;
  logic [FRAC_W-1:0]    ta_nxt, tb_nxt, tc_nxt, td_nxt, te_nxt, num_nxt, den_nxt;

  // filmic offset, then shift x and unit down until x fits the curve range
  always_comb begin
    if (op == OP_FILMIC) begin
      xf = (x1_r > XW'(FILMIC_OFFSET)) ? x1_r - XW'(FILMIC_OFFSET) : '0;
    end else begin
      xf = x1_r;
    end
    sh = '0;
    for (int i = CURVE_W; i < XW; i++) begin
      if (xf[i]) begin
        sh = SHIFT_W'(i - CURVE_W + 1);
      end
    end
    xs  = CURVE_W'(xf >> sh);
    ush = UNIT_SHIFT - sh;
  end

  always_comb begin
    ta_nxt = '0;
    tb_nxt = '0;
    tc_nxt = '0;
    td_nxt = '0;
    te_nxt = '0;
    case (op)
      OP_ACES: begin
        ta_nxt = FRAC_W'(sq3_r) * FRAC_W'(ACES_A);
        tb_nxt = FRAC_W'(xu3_r) * FRAC_W'(ACES_B);
        tc_nxt = FRAC_W'(sq3_r) * FRAC_W'(ACES_C);
        td_nxt = FRAC_W'(xu3_r) * FRAC_W'(ACES_D);
        te_nxt = FRAC_W'(u2_3_r) * FRAC_W'(ACES_E);
      end
      OP_UNCH: begin
        ta_nxt = FRAC_W'(sq3_r) * FRAC_W'(UNCH_A);
        tb_nxt = FRAC_W'(xu3_r) * FRAC_W'(UNCH_B);
        tc_nxt = FRAC_W'(sq3_r) * FRAC_W'(UNCH_C);
        td_nxt = FRAC_W'(xu3_r) * FRAC_W'(UNCH_D);
        te_nxt = FRAC_W'(u2_3_r) * FRAC_W'(UNCH_E);
      end
      OP_FILMIC: begin
        ta_nxt = FRAC_W'(sq3_r) * FRAC_W'(FILM_A);
        tb_nxt = FRAC_W'(xu3_r) * FRAC_W'(FILM_B);
        tc_nxt = FRAC_W'(sq3_r) * FRAC_W'(FILM_C);
        td_nxt = FRAC_W'(xu3_r) * FRAC_W'(FILM_D);
        te_nxt = FRAC_W'(u2_3_r) * FRAC_W'(FILM_E);
      end
      default: begin
        ta_nxt = '0;
      end
    endcase
  end

  always_comb begin
    if (op inside {OP_ACES, OP_UNCH, OP_FILMIC}) begin
      num_nxt = ta_r + tb_r;
      den_nxt = tc_r + td_r + te_r;
    end else if (op inside {OP_REINHARD, OP_JODIE}) begin
      num_nxt = FRAC_W'(x4_r);
      den_nxt = FRAC_W'(x4_r) + UNIT_ONE;
    end else begin
      num_nxt = FRAC_W'(x4_r);
      den_nxt = UNIT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= XW'(chan) * XW'(gain);
      x2_r   <= x1_r;
      xs2_r  <= xs;
      ush2_r <= ush;
      x3_r   <= x2_r;
      sq3_r  <= SQ_W'(xs2_r) * SQ_W'(xs2_r);
      xu3_r  <= XU_W'(xs2_r) << ush2_r;
      u2_3_r <= U2_W'(1) << {ush2_r, 1'b0};
      x4_r   <= x3_r;
      ta_r   <= ta_nxt;
      tb_r   <= tb_nxt;
      tc_r   <= tc_nxt;
      td_r   <= td_nxt;
      te_r   <= te_nxt;
      num_r  <= num_nxt;
      den_r  <= den_nxt;
    end
  end

  assign x_s1      = x1_r;
  assign out_valid = v_r[4];
  assign num       = num_r;
  assign den       = den_r;

endmodule

/* hdl/htm_div.sv */
// pipelined restoring divider, one quotient bit per stage, saturating
module htm_div import htm_pkg::*; #(
  parameter int W  = 16,
  parameter int DW = 64,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [DW-1:0] in_den,
  input  logic [W-1:0]  in_bits,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [W-1:0]  out_quo,
  output logic [SW-1:0] out_side
);

  logic [W:0]    v_r;
  logic [W:0]    sat_r;
  logic [DW-1:0] rem_r  [W];
  logic [DW-1:0] den_r  [W];
  logic [W-1:0]  bits_r [W];
  logic [W-1:0]  quo_r  [W+1];
  logic [SW-1:0] side_r [W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[W-1:0], in_valid};
    end
  end

  // entry stage: numerator not below divisor saturates
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= in_rem;
      den_r[0]  <= in_den;
      bits_r[0] <= in_bits;
      quo_r[0]  <= '0;
      side_r[0] <= in_side;
      sat_r[0]  <= (in_rem >= in_den);
    end
  end

  for (genvar g = 0; g < W; g++) begin : g_step
    logic [DW:0] r2;
    logic [DW:0] diff;
    logic        ge;

    assign r2   = {rem_r[g], bits_r[g][W-1]};
    assign diff = r2 - {1'b0, den_r[g]};
    assign ge   = (r2 >= {1'b0, den_r[g]});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[g+1]  <= {quo_r[g][W-2:0], ge};
        side_r[g+1] <= side_r[g];
        sat_r[g+1]  <= sat_r[g];
      end
    end

    if (g < W - 1) begin : g_more
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g+1]  <= ge ? diff[DW-1:0] : r2[DW-1:0];
          den_r[g+1]  <= den_r[g];
          bits_r[g+1] <= bits_r[g] << 1;
        end
      end
    end
  end

  assign out_valid = v_r[W];
  assign out_quo   = sat_r[W] ? '1 : quo_r[W];
  assign out_side  = side_r[W];

endmodule

/* hdl/hdr_tone_mapper_unit.sv */
// hdr tone mapper: from the accepting edge to out_valid a pixel passes five front stages,
// two dividers of CHANNEL_WIDTH+1 stages each and one mix stage between them, then the
// output register
// throughput one pixel per clock; the whole pipe advances together and holds on a stall
// rst_n synchronous: clears all valid bits, operator_select to linear, exposure_gain to 1.0
module hdr_tone_mapper_unit import htm_pkg::*; #(
  parameter int CHANNEL_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CHANNEL_WIDTH-1:0] in_red_in,
  input  logic [CHANNEL_WIDTH-1:0] in_green_in,
  input  logic [CHANNEL_WIDTH-1:0] in_blue_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CHANNEL_WIDTH-1:0] out_red_out,
  output logic [CHANNEL_WIDTH-1:0] out_green_out,
  output logic [CHANNEL_WIDTH-1:0] out_blue_out
);

  localparam int W  = CHANNEL_WIDTH;
  localparam int XW = W + GAIN_W;
  // luminance times 10000 plus the jodie base
  localparam int LW = XW + 14;

  // configuration registers
  op_code_t          op_r;
  logic [GAIN_W-1:0] gain_r;

  // pipe control
  logic en;
  logic last_valid;

  // per lane signals
  logic [W-1:0]      chan_in [3];
  logic [XW-1:0]     x1      [3];
  logic [FRAC_W-1:0] num1    [3];
  logic [FRAC_W-1:0] den1    [3];
  logic [W-1:0]      q1      [3];
  logic [LW-1:0]     side1   [3];
  logic [LW-1:0]     rem2_r  [3];
  logic [LW-1:0]     d2_r    [3];
  logic [W-1:0]      bits2_r [3];
  logic [W-1:0]      t2_r    [3];
  logic [W-1:0]      q2      [3];
  logic [W-1:0]      t2o     [3];
  logic [W-1:0]      res     [3];
  logic [2:0]        fv, d1v, d2v;
  logic              j_valid_r;

  // luminance side pipe, aligned with the front stages
  logic [LW-1:0]     lp_r [3];
  logic [LW-1:0]     lum_r;
  logic [LW-1:0]     den2_4_r, den2_5_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [W-1:0]      out_r [3];

  // apb port, always ready, word address in paddr[2]
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r   <= OP_LINEAR;
      gain_r <= 16'd256;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[2]))
        REG_OPERATOR: op_r   <= pwdata[2:0];
        REG_EXPOSURE: gain_r <= pwdata[GAIN_W-1:0];
        default:      op_r   <= op_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_OPERATOR: prdata = {29'd0, op_r};
      REG_EXPOSURE: prdata = {16'd0, gain_r};
      default:      prdata = '0;
    endcase
  end

  // whole pipe moves unless a finished beat sits in both the last stage and the
  // output register with the consumer stalled
  assign en       = !last_valid || !out_valid_r || out_ready;
  assign in_ready = en;

  assign chan_in[0] = in_red_in;
  assign chan_in[1] = in_green_in;
  assign chan_in[2] = in_blue_in;

  // luminance: products, sum, base, then one alignment stage
  always_ff @(posedge clk) begin
    if (en) begin
      lp_r[0]  <= LW'(x1[0]) * LW'(LUM_R);
      lp_r[1]  <= LW'(x1[1]) * LW'(LUM_G);
      lp_r[2]  <= LW'(x1[2]) * LW'(LUM_B);
      lum_r    <= lp_r[0] + lp_r[1] + lp_r[2];
      den2_4_r <= lum_r + LW'(JODIE_BASE);
      den2_5_r <= den2_4_r;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic [LW-1:0]  n2;
    logic [2*W-1:0] tsq;
    logic [W:0]     s;

    htm_front #(.W(W)) u_front (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (in_valid),
      .chan      (chan_in[c]),
      .gain      (gain_r),
      .op        (op_r),
      .x_s1      (x1[c]),
      .out_valid (fv[c]),
      .num       (num1[c]),
      .den       (den1[c])
    );

    // first division: curve value, or the reinhard code for jodie
    htm_div #(.W(W), .DW(FRAC_W), .SW(LW)) u_div1 (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (&fv),
      .in_rem    (num1[c]),
      .in_den    (den1[c]),
      .in_bits   ('0),
      .in_side   (den2_5_r),
      .out_valid (d1v[c]),
      .out_quo   (q1[c]),
      .out_side  (side1[c])
    );

    // jodie mix: tc*base/(base+lum) goes to the second divider, tc*tc/2^w rides
    // alongside; other operators pass the code through a divide by one
    assign n2  = LW'(q1[c]) * LW'(JODIE_BASE);
    assign tsq = (2*W)'(q1[c]) * (2*W)'(q1[c]);

    always_ff @(posedge clk) begin
      if (en) begin
        if (op_r == OP_JODIE) begin
          rem2_r[c]  <= LW'(n2 >> W);
          bits2_r[c] <= n2[W-1:0];
          d2_r[c]    <= side1[c];
          t2_r[c]    <= tsq[2*W-1:W];
        end else begin
          rem2_r[c]  <= '0;
          bits2_r[c] <= q1[c];
          d2_r[c]    <= LW'(1);
          t2_r[c]    <= '0;
        end
      end
    end

    htm_div #(.W(W), .DW(LW), .SW(W)) u_div2 (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (j_valid_r),
      .in_rem    (rem2_r[c]),
      .in_den    (d2_r[c]),
      .in_bits   (bits2_r[c]),
      .in_side   (t2_r[c]),
      .out_valid (d2v[c]),
      .out_quo   (q2[c]),
      .out_side  (t2o[c])
    );

    // final sum, saturated at 1.0
    assign s      = (W+1)'(q2[c]) + (W+1)'(t2o[c]);
    assign res[c] = s[W] ? '1 : s[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_valid_r <= 1'b0;
    end else if (en) begin
      j_valid_r <= &d1v;
    end
  end

  assign last_valid = &d2v;

  // output beat register
  always_comb begin
    if (last_valid && en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (last_valid && en) begin
      out_r[0] <= res[0];
      out_r[1] <= res[1];
      out_r[2] <= res[2];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_r[0];
  assign out_green_out = out_r[1];
  assign out_blue_out  = out_r[2];

  // a full pipe with a stalled consumer must refuse input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (last_valid && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while the pipe is stalled");

  // the three lanes move in lock step
  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(d1v) == 0) || ($countones(d1v) == 3))
    else $error("lane valids disagree after the first divider");

  // a new output beat only comes from the last pipe stage
  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(last_valid))
    else $error("output beat without a finished pipe stage");

endmodule

/* bench/tone_checker.sv */
// checker for the hdr tone mapper: tracks the registers, predicts each pixel and compares results
module tone_checker import htm_pkg::*; #(
  parameter int CHANNEL_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [CHANNEL_WIDTH-1:0] in_red_in,
  input  logic [CHANNEL_WIDTH-1:0] in_green_in,
  input  logic [CHANNEL_WIDTH-1:0] in_blue_in,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [CHANNEL_WIDTH-1:0] out_red_out,
  input  logic [CHANNEL_WIDTH-1:0] out_green_out,
  input  logic [CHANNEL_WIDTH-1:0] out_blue_out,
  output int                       errors,
  output int                       pending
);

  typedef bit [CHANNEL_WIDTH-1:0] chan_t;
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  localparam bit [63:0] ONE_Q16   = 64'd65536;
  localparam bit [63:0] CODE_MAX  = (64'd1 << CHANNEL_WIDTH) - 1;
  localparam bit [63:0] CURVE_TOP = 64'd1 << CURVE_W;

  op_code_t       op_sel;
  bit [15:0]      gain;
  pixel_t         expected_pixels[$];

  // floor(num * 2^W / den), all ones when the fraction reaches 1.0
  function automatic bit [63:0] frac_code(bit [63:0] num, bit [63:0] den);
    bit [63:0] q;
    bit [63:0] r;
    q = 0;
    r = num;
    if (den == 0 || num >= den) return CODE_MAX;
    for (int i = 0; i < CHANNEL_WIDTH; i++) begin
      q = q << 1;
      if (r >= den - r) begin
        r = r - (den - r);
        q = q | 1;
      end else begin
        r = r + r;
      end
    end
    return q;
  endfunction

  function automatic bit [63:0] curve_code(op_code_t op, bit [63:0] x);
    bit [63:0] u;
    u = ONE_Q16;
    if (op == OP_FILMIC) x = (x > 262) ? x - 262 : 0;
    if (op == OP_ACES || op == OP_UNCH || op == OP_FILMIC) begin
      // keep the products inside 64 bits, unit stays a power of two
      while (x >= CURVE_TOP) begin
        x = x >> 1;
        u = u >> 1;
      end
    end
    case (op)
      OP_ACES:     return frac_code(x * (251 * x + 3 * u), x * (243 * x + 59 * u) + 14 * u * u);
      OP_UNCH:     return frac_code(x * (210 * x + 25 * u),
                                    225 * x * x + 750 * x * u + 90 * u * u);
      OP_FILMIC:   return frac_code(x * (310 * x + 25 * u), x * (310 * x + 85 * u) + 3 * u * u);
      OP_REINHARD: return frac_code(x, ONE_Q16 + x);
      default:     return frac_code(x, ONE_Q16);
    endcase
  endfunction

  function automatic pixel_t tone_pixel(pixel_t p);
    bit [63:0] x[3];
    bit [63:0] lum, base, tc, mixed;
    bit [63:0] y[3];
    pixel_t    res;
    x[0] = 64'(p.red) * gain;
    x[1] = 64'(p.green) * gain;
    x[2] = 64'(p.blue) * gain;
    if (op_sel == OP_JODIE) begin
      lum  = 2126 * x[0] + 7152 * x[1] + 722 * x[2];
      base = 64'd10000 * ONE_Q16;
      for (int k = 0; k < 3; k++) begin
        tc    = frac_code(x[k], ONE_Q16 + x[k]);
        mixed = (tc * base) / (base + lum) + ((tc * tc) >> CHANNEL_WIDTH);
        y[k]  = (mixed > CODE_MAX) ? CODE_MAX : mixed;
      end
    end else begin
      for (int k = 0; k < 3; k++) y[k] = curve_code(op_sel, x[k]);
    end
    res.red   = chan_t'(y[0]);
    res.green = chan_t'(y[1]);
    res.blue  = chan_t'(y[2]);
    return res;
  endfunction

  task automatic report_mismatch(string what, chan_t got, chan_t want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst_n) begin
      op_sel = OP_LINEAR;
      gain   = 16'd256;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (reg_idx_t'(paddr[2]) == REG_OPERATOR) op_sel = op_code_t'(pwdata[2:0]);
        else gain = pwdata[15:0];
      end
      if (in_valid && in_ready)
        expected_pixels = {expected_pixels,
                           tone_pixel('{in_red_in, in_green_in, in_blue_in})};
      if (out_valid && out_ready) begin
        got = '{out_red_out, out_green_out, out_blue_out};
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected beat, red", got.red, '0);
        end else begin
          want = expected_pixels.pop_front();
          if (got.red != want.red) report_mismatch("red", got.red, want.red);
          if (got.green != want.green) report_mismatch("green", got.green, want.green);
          if (got.blue != want.blue) report_mismatch("blue", got.blue, want.blue);
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

/* bench/testbench.sv */
// top of the hdr tone mapper bench: stimulus, register set-up and verdict
module testbench import htm_pkg::*;;

  localparam int CW         = 16;
  localparam int LATENCY    = 2 * CW + 8;
  localparam int CYCLE_CAP  = 500000;
  localparam int LONG_HOLD  = 300;

  logic          clk;
  logic          rst_n;
  logic          psel, penable, pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;
  logic          in_valid, in_ready;
  logic [CW-1:0] in_red_in, in_green_in, in_blue_in;
  logic          out_valid, out_ready;
  logic [CW-1:0] out_red_out, out_green_out, out_blue_out;

  int errors;
  int pending;
  int cycles;
  bit hold_req;   // asks the receiver for one long hold-off

  hdr_tone_mapper_unit #(.CHANNEL_WIDTH(CW)) u_dut (.*);

  tone_checker #(.CHANNEL_WIDTH(CW)) u_checker (
    .clk, .rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_ready, .in_red_in, .in_green_in, .in_blue_in,
    .out_valid, .out_ready, .out_red_out, .out_green_out, .out_blue_out,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog on total run length
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // gap length: mostly short, now and then long
  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // receiver: random stalls, runs with none, and one long hold-off on request
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end
      n = gap_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // each write drops psel before it returns so back to back writes never collide
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // in_valid stays high straight into the next beat when there is no gap
  task automatic send_pixel(logic [CW-1:0] r, logic [CW-1:0] g, logic [CW-1:0] b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [CW-1:0] pick_chan();
    case ($urandom_range(0, 4))
      0:       return CW'($urandom());
      1:       return CW'($urandom_range(0, 1023));
      2:       return CW'($urandom_range(0, 16'h3fff));
      3:       return $urandom_range(0, 1) ? '1 : '0;
      default: return CW'($urandom_range(0, 300));
    endcase
  endfunction

  // wait for the pipe to drain before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    logic [15:0] g;
    int          phase;
    hold_req    = 1'b0;
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    in_red_in   = '0;
    in_green_in = '0;
    in_blue_in  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: linear at unity exposure
    send_pixel('0, '1, 16'h0100);
    send_pixel(16'h00ff, 16'h0101, 16'h0001);
    drain();

    phase = 0;
    for (int op = 0; op < 8; op++) begin
      for (int gsel = 0; gsel < 5; gsel++) begin
        case (gsel)
          0:       g = 16'd256;
          1:       g = 16'd0;
          2:       g = 16'hffff;
          3:       g = 16'($urandom_range(1, 1023));
          default: g = 16'($urandom());
        endcase
        // junk in the unused upper bits must be ignored
        write_reg(REG_OPERATOR, {$urandom_range(0, 1) ? 29'($urandom()) : 29'd0, 3'(op)});
        write_reg(REG_EXPOSURE, {16'($urandom()), g});
        // extremes, the filmic offset and the range-scaling region
        send_pixel('0, '0, '0);
        send_pixel('1, '1, '1);
        send_pixel(16'h0001, 16'h8000, 16'h0105);
        // the long hold-off phase keeps offering beats until the pipe fills
        for (int i = 0; i < ((phase == 12) ? 100 : 12); i++) begin
          if (phase == 12 && i == 2) hold_req = 1'b1;
          send_pixel(pick_chan(), pick_chan(), pick_chan());
        end
        // one phase pauses the sender mid-stream until every result is back
        if (phase == 20) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
          for (int i = 0; i < 6; i++) send_pixel(pick_chan(), pick_chan(), pick_chan());
        end
        drain();
        phase++;
      end
    end

    repeat (LATENCY) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/htm_pkg.sv
hdl/htm_front.sv
hdl/htm_div.sv
hdl/hdr_tone_mapper_unit.sv
bench/tone_checker.sv
bench/testbench.sv
